/* rtl/core/kesf_pkg.sv */
// ----------------------------------------------------------------------------
// kesf_pkg
// Shared types and constants for the key event search FIFO.
// ----------------------------------------------------------------------------
package kesf_pkg;

    localparam int KEY_W  = 8;
    localparam int FILL_W = 5;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_SEARCH = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_SCAN = 3'b100
    } t_state;

    typedef struct packed {
        logic             flag;
        logic [KEY_W-1:0] key;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

/* rtl/core/kesf_if.sv */
// ----------------------------------------------------------------------------
// kesf_if
// Valid/ready channels carrying operations in and results out.
// ----------------------------------------------------------------------------
interface kesf_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 opcode;
    logic [kesf_pkg::KEY_W-1:0] key_code;
    logic                       block_flag;

    modport source (output valid, output opcode, output key_code, output block_flag,
                    input ready);
    modport sink   (input valid, input opcode, input key_code, input block_flag,
                    output ready);
endinterface

interface kesf_out_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic                        blocked;
    logic                        dropped_oldest;
    logic [kesf_pkg::FILL_W-1:0] fill_level;

    modport source (output valid, output found, output blocked, output dropped_oldest,
                    output fill_level, input ready);
    modport sink   (input valid, input found, input blocked, input dropped_oldest,
                    input fill_level, output ready);
endinterface

/* rtl/core/kesf_cell.sv */
// ----------------------------------------------------------------------------
// kesf_cell
// One storage cell of the event chain: loads a new event or takes its
// neighbor's entry when the chain shifts toward the head.
// ----------------------------------------------------------------------------
module kesf_cell (
    input  logic                i_clk,
    input  kesf_pkg::t_cell_ctl i_ctl,
    input  kesf_pkg::t_entry    i_new,
    input  kesf_pkg::t_entry    i_next,
    output kesf_pkg::t_entry    o_entry
);

    kesf_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_new;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

/* rtl/core/key_event_search_fifo.sv */
// ----------------------------------------------------------------------------
// key_event_search_fifo
// FIFO of key events held in a ring of cells; cell 0 is the head. A search
// rotates the ring one cell per cycle and stops on the first matching key,
// which leaves the match at the head with older entries past the tail.
// ----------------------------------------------------------------------------
// push, clear and unused opcodes: result registered from ST_EXEC once the output register is free
// search: result registered from ST_SCAN once a match reaches the head, or after a
//   full ring rotation when nothing matches (the full rotation restores order)
// one transaction at a time; the next is accepted once the result is in the
//   output register, which may still wait for the sink
// synchronous active-low reset empties the FIFO; stored events are not cleared
module key_event_search_fifo #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    kesf_in_if.sink        i_in,
    kesf_out_if.source     o_out
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int IW = $clog2(FIFO_DEPTH);

    kesf_pkg::t_state r_state, n_state;
    kesf_pkg::t_op    r_op, n_op;
    logic [kesf_pkg::KEY_W-1:0] r_key, n_key;
    logic             r_flag, n_flag;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_step, n_step;

    logic             r_out_valid, n_out_valid;
    logic             r_found, r_blocked, r_dropped;
    logic [kesf_pkg::FILL_W-1:0] r_fill;

    logic             w_out_free, w_out_write;
    logic             w_found, w_blocked, w_dropped;
    logic             w_push, w_rotate, w_full, w_hit;
    logic [CW+kesf_pkg::FILL_W-1:0] w_fill_ext;

    kesf_pkg::t_entry    w_entry [FIFO_DEPTH];
    kesf_pkg::t_cell_ctl w_ctl   [FIFO_DEPTH];
    kesf_pkg::t_entry    w_new;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_full     = (r_count == CW'(FIFO_DEPTH));
    assign w_hit      = (r_step < r_count) && (w_entry[0].key == r_key);
    assign w_new      = '{flag: r_flag, key: r_key};

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_flag      = r_flag;
        n_count     = r_count;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        w_out_write = 1'b0;
        w_found     = 1'b0;
        w_blocked   = 1'b0;
        w_dropped   = 1'b0;
        w_push      = 1'b0;
        w_rotate    = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            kesf_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_op   = kesf_pkg::t_op'(i_in.opcode);
                    n_key  = i_in.key_code;
                    n_flag = i_in.block_flag;
                    n_step = '0;
                    n_state = (kesf_pkg::t_op'(i_in.opcode) == kesf_pkg::OP_SEARCH)
                            ? kesf_pkg::ST_SCAN : kesf_pkg::ST_EXEC;
                end
            end
            kesf_pkg::ST_EXEC: begin
                if (w_out_free) begin
                    w_out_write = 1'b1;
                    case (r_op)
                        kesf_pkg::OP_PUSH: begin
                            w_push = 1'b1;
                            if (w_full) begin
                                w_dropped = 1'b1;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        kesf_pkg::OP_CLEAR: n_count = '0;
                        default: ;
                    endcase
                    n_state = kesf_pkg::ST_IDLE;
                end
            end
            kesf_pkg::ST_SCAN: begin
                if (w_hit) begin
                    if (w_out_free) begin
                        w_out_write = 1'b1;
                        w_found     = 1'b1;
                        w_blocked   = w_entry[0].flag;
                        // entries rotated past the tail are the dropped older ones
                        n_count     = r_count - r_step;
                        n_state     = kesf_pkg::ST_IDLE;
                    end
                end else if (r_step == CW'(FIFO_DEPTH)) begin
                    if (w_out_free) begin
                        w_out_write = 1'b1;
                        n_state     = kesf_pkg::ST_IDLE;
                    end
                end else begin
                    w_rotate = 1'b1;
                    n_step   = r_step + CW'(1);
                end
            end
            default: n_state = kesf_pkg::ST_IDLE;
        endcase

        if (w_out_write) begin
            n_out_valid = 1'b1;
        end
    end

    assign w_fill_ext = {{kesf_pkg::FILL_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kesf_pkg::ST_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_key  <= n_key;
        r_flag <= n_flag;
        if (w_out_write) begin
            r_found   <= w_found;
            r_blocked <= w_blocked;
            r_dropped <= w_dropped;
            r_fill    <= w_fill_ext[kesf_pkg::FILL_W-1:0];
        end
    end

    // cell chain: a full push shifts out the head and loads the last cell
    for (genvar k = 0; k < FIFO_DEPTH; k++) begin : g_cell
        localparam int NXT = (k + 1) % FIFO_DEPTH;

        assign w_ctl[k].shift = w_rotate || (w_push && w_full);
        assign w_ctl[k].load  = w_push && (w_full ? (k == FIFO_DEPTH - 1)
                                                  : (r_count[IW-1:0] == IW'(k)));

        kesf_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[k]),
            .i_new   (w_new),
            .i_next  (w_entry[NXT]),
            .o_entry (w_entry[k])
        );
    end

    assign i_in.ready           = (r_state == kesf_pkg::ST_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.found          = r_found;
    assign o_out.blocked        = r_blocked;
    assign o_out.dropped_oldest = r_dropped;
    assign o_out.fill_level     = r_fill;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(FIFO_DEPTH))
        else $error("entry count beyond depth");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kesf_pkg::ST_SCAN) |-> (r_step <= CW'(FIFO_DEPTH)))
        else $error("scan ran past a full rotation");

    a_blocked_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.blocked && !o_out.found))
        else $error("blocked reported without a match");

    a_found_not_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.found && o_out.dropped_oldest))
        else $error("search and push results mixed");

    a_rotate_idle_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rotate |-> (r_state == kesf_pkg::ST_SCAN) && !w_push)
        else $error("ring rotation outside a search");

endmodule
